FILE: hdl/hilbert_3d_codec_assert.svh
// Assertion macros for the 3D Hilbert codec checker.
`ifndef HILBERT_3D_CODEC_ASSERT_SVH
`define HILBERT_3D_CODEC_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HC3D_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hc3d: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define HC3D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hc3d: next-cycle check failed");

// Condition that must hold in the cycle after reset is applied.
`define HC3D_ASSERT_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("hc3d: post-reset check failed");

`endif

FILE: hdl/hc3d_pkg.sv
`timescale 1ns / 1ps
package hc3d_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int CRD_W          = 21;
  localparam int IDX_W          = 63;
  localparam int LVL_W          = 5;
  localparam int ST_W           = 4;
  localparam int NUM_STATES     = 12;
  localparam int ENT_W          = 7;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Entry = {next state, digit}, indexed [state][octant]
  localparam logic [ENT_W-1:0] FWD_TAB [0:NUM_STATES-1][0:7] = '{
    '{7'd8,  7'd17, 7'd27, 7'd18, 7'd47, 7'd38, 7'd28, 7'd37},
    '{7'd16, 7'd71, 7'd1,  7'd62, 7'd51, 7'd52, 7'd2,  7'd61},
    '{7'd0,  7'd75, 7'd95, 7'd76, 7'd9,  7'd10, 7'd86, 7'd85},
    '{7'd4,  7'd77, 7'd55, 7'd78, 7'd3,  7'd66, 7'd80, 7'd65},
    '{7'd50, 7'd49, 7'd45, 7'd46, 7'd67, 7'd88, 7'd68, 7'd7},
    '{7'd6,  7'd57, 7'd39, 7'd72, 7'd5,  7'd58, 7'd84, 7'd83},
    '{7'd12, 7'd11, 7'd29, 7'd90, 7'd79, 7'd32, 7'd30, 7'd89},
    '{7'd74, 7'd91, 7'd73, 7'd40, 7'd69, 7'd92, 7'd70, 7'd15},
    '{7'd14, 7'd13, 7'd81, 7'd82, 7'd63, 7'd36, 7'd24, 7'd35},
    '{7'd20, 7'd31, 7'd19, 7'd56, 7'd53, 7'd54, 7'd42, 7'd41},
    '{7'd26, 7'd93, 7'd43, 7'd44, 7'd25, 7'd94, 7'd64, 7'd23},
    '{7'd22, 7'd87, 7'd21, 7'd60, 7'd33, 7'd48, 7'd34, 7'd59}
  };

  // Entry = {next state, octant}, indexed [state][digit]
  localparam logic [ENT_W-1:0] INV_TAB [0:NUM_STATES-1][0:7] = '{
    '{7'd8,  7'd17, 7'd19, 7'd26, 7'd30, 7'd39, 7'd37, 7'd44},
    '{7'd16, 7'd2,  7'd6,  7'd52, 7'd53, 7'd63, 7'd59, 7'd65},
    '{7'd0,  7'd12, 7'd13, 7'd73, 7'd75, 7'd87, 7'd86, 7'd90},
    '{7'd86, 7'd71, 7'd69, 7'd4,  7'd0,  7'd73, 7'd75, 7'd50},
    '{7'd93, 7'd49, 7'd48, 7'd68, 7'd70, 7'd42, 7'd43, 7'd7},
    '{7'd75, 7'd57, 7'd61, 7'd87, 7'd86, 7'd4,  7'd0,  7'd34},
    '{7'd37, 7'd95, 7'd91, 7'd9,  7'd8,  7'd26, 7'd30, 7'd76},
    '{7'd43, 7'd74, 7'd72, 7'd89, 7'd93, 7'd68, 7'd70, 7'd15},
    '{7'd30, 7'd82, 7'd83, 7'd39, 7'd37, 7'd9,  7'd8,  7'd60},
    '{7'd59, 7'd47, 7'd46, 7'd18, 7'd16, 7'd52, 7'd53, 7'd25},
    '{7'd70, 7'd28, 7'd24, 7'd42, 7'd43, 7'd89, 7'd93, 7'd23},
    '{7'd53, 7'd36, 7'd38, 7'd63, 7'd59, 7'd18, 7'd16, 7'd81}
  };

endpackage

FILE: hdl/hilbert_3d_codec.sv
`timescale 1ns / 1ps
// 3D Hilbert curve codec.
// Input channel: in_valid / in_stall carry cmd, x_coord, y_coord, z_coord,
// hilbert_index and depth_level. cmd = encode turns coordinates into an index;
// cmd = decode turns an index into coordinates. The field the other command
// fills is returned as zero.
// Output channel: out_valid / out_stall carry index_out, x_out, y_out, z_out.
// A transaction is taken on a clock edge with valid high and stall low.
// The pipeline has one stage per refinement level (COORD_BITS stages), each
// doing one automaton table step. Throughput is one transaction per cycle
// while the output is not stalled.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped or
// repeated. Bubbles are not squeezed out.
// Synchronous reset clears all stage valid bits; the block accepts input in
// the first cycle after reset.
module hilbert_3d_codec
  import hc3d_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [CRD_W-1:0]  x_coord,
  input  logic [CRD_W-1:0]  y_coord,
  input  logic [CRD_W-1:0]  z_coord,
  input  logic [IDX_W-1:0]  hilbert_index,
  input  logic [LVL_W-1:0]  depth_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  index_out,
  output logic [CRD_W-1:0]  x_out,
  output logic [CRD_W-1:0]  y_out,
  output logic [CRD_W-1:0]  z_out
);

  localparam int ACC_W = 3 * COORD_BITS;
  localparam int LAST  = COORD_BITS - 1;

  logic                  stage_vld [COORD_BITS];
  logic                  stage_cmd [COORD_BITS];
  logic [LVL_W-1:0]      stage_lvl [COORD_BITS];
  logic [ST_W-1:0]       stage_st  [COORD_BITS];
  logic [ACC_W-1:0]      stage_acc [COORD_BITS];
  logic [ACC_W-1:0]      stage_idx [COORD_BITS];
  logic [COORD_BITS-1:0] stage_x   [COORD_BITS];
  logic [COORD_BITS-1:0] stage_y   [COORD_BITS];
  logic [COORD_BITS-1:0] stage_z   [COORD_BITS];

  logic                  adv;
  logic [COORD_BITS-1:0] x_dec;
  logic [COORD_BITS-1:0] y_dec;
  logic [COORD_BITS-1:0] z_dec;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  for (genvar s = 0; s < COORD_BITS; s++) begin : g_stage
    // bit position handled by this stage, top level first
    localparam int B = COORD_BITS - 1 - s;

    logic                  vld_i;
    logic                  cmd_i;
    logic [LVL_W-1:0]      lvl_i;
    logic [ST_W-1:0]       st_i;
    logic [ACC_W-1:0]      acc_i;
    logic [ACC_W-1:0]      idx_i;
    logic [COORD_BITS-1:0] x_i;
    logic [COORD_BITS-1:0] y_i;
    logic [COORD_BITS-1:0] z_i;
    logic [2:0]            key;
    logic [ENT_W-1:0]      ent;
    logic                  act;

    if (s == 0) begin : g_head
      assign vld_i = in_valid;
      assign cmd_i = cmd;
      assign lvl_i = depth_level;
      assign st_i  = '0;
      assign acc_i = '0;
      assign idx_i = hilbert_index[ACC_W-1:0];
      assign x_i   = x_coord[COORD_BITS-1:0];
      assign y_i   = y_coord[COORD_BITS-1:0];
      assign z_i   = z_coord[COORD_BITS-1:0];
    end else begin : g_body
      assign vld_i = stage_vld[s-1];
      assign cmd_i = stage_cmd[s-1];
      assign lvl_i = stage_lvl[s-1];
      assign st_i  = stage_st[s-1];
      assign acc_i = stage_acc[s-1];
      assign idx_i = stage_idx[s-1];
      assign x_i   = stage_x[s-1];
      assign y_i   = stage_y[s-1];
      assign z_i   = stage_z[s-1];
    end

    // Levels above depth_level leave state at 0 and shift in a zero digit,
    // which matches skipping them. Levels above COORD_BITS clamp for free.
    always_comb begin
      act = (lvl_i > LVL_W'(B));
      if (cmd_i == CMD_DECODE) begin
        key = idx_i[3*B +: 3];
        ent = INV_TAB[st_i][key];
      end else begin
        key = {z_i[B], y_i[B], x_i[B]};
        ent = FWD_TAB[st_i][key];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld[s] <= 1'b0;
      end else if (adv) begin
        stage_vld[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_cmd[s] <= cmd_i;
        stage_lvl[s] <= lvl_i;
        stage_idx[s] <= idx_i;
        stage_x[s]   <= x_i;
        stage_y[s]   <= y_i;
        stage_z[s]   <= z_i;
        stage_st[s]  <= act ? ent[ENT_W-1:3] : '0;
        stage_acc[s] <= (acc_i << 3) | ACC_W'(act ? ent[2:0] : 3'b000);
      end
    end
  end

  // Decode accumulates octants; split them back into per-axis bits.
  always_comb begin
    for (int i = 0; i < COORD_BITS; i++) begin
      x_dec[i] = stage_acc[LAST][3*i];
      y_dec[i] = stage_acc[LAST][3*i+1];
      z_dec[i] = stage_acc[LAST][3*i+2];
    end
  end

  assign out_valid = stage_vld[LAST];
  assign index_out = (stage_cmd[LAST] == CMD_ENCODE) ? IDX_W'(stage_acc[LAST]) : '0;
  assign x_out     = (stage_cmd[LAST] == CMD_DECODE) ? CRD_W'(x_dec) : '0;
  assign y_out     = (stage_cmd[LAST] == CMD_DECODE) ? CRD_W'(y_dec) : '0;
  assign z_out     = (stage_cmd[LAST] == CMD_DECODE) ? CRD_W'(z_dec) : '0;

endmodule

FILE: hdl/hc3d_checker.sv
`timescale 1ns / 1ps
`include "hilbert_3d_codec_assert.svh"
module hc3d_checker
  import hc3d_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] index_out,
  input logic [CRD_W-1:0] x_out,
  input logic [CRD_W-1:0] y_out,
  input logic [CRD_W-1:0] z_out
);

  logic                     out_held;
  logic                     coords_zero;
  logic [IDX_W+3*CRD_W-1:0] out_payload;

  assign out_held    = out_valid && out_stall;
  assign coords_zero = (x_out == '0) && (y_out == '0) && (z_out == '0);
  assign out_payload = {index_out, x_out, y_out, z_out};

  // a waiting result blocks the input side in the same cycle
  `HC3D_ASSERT_SAME(a_stall_backpressure, clk, rst, out_held, in_stall)

  // nonzero index only comes from encode, whose coordinates are zero
  `HC3D_ASSERT_SAME(a_encode_coords_zero, clk, rst, out_valid && (index_out != '0), coords_zero)

  // stalled result holds its payload
  `HC3D_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_payload))

  // pipeline empties on reset
  `HC3D_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid && !in_stall)

endmodule

bind hilbert_3d_codec hc3d_checker u_hc3d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .index_out (index_out),
  .x_out     (x_out),
  .y_out     (y_out),
  .z_out     (z_out)
);

FILE: dv/hilbert_3d_codec_chk.sv
`timescale 1ns / 1ps
module hilbert_3d_codec_chk
  import hc3d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             cmd,
  input  logic [CRD_W-1:0] x_coord,
  input  logic [CRD_W-1:0] y_coord,
  input  logic [CRD_W-1:0] z_coord,
  input  logic [IDX_W-1:0] hilbert_index,
  input  logic [LVL_W-1:0] depth_level,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [IDX_W-1:0] index_out,
  input  logic [CRD_W-1:0] x_out,
  input  logic [CRD_W-1:0] y_out,
  input  logic [CRD_W-1:0] z_out,
  output int               mismatches,
  output int               outstanding,
  output int               matched
);

  localparam int MAX_LEVEL = COORD_BITS_DEF;
  localparam int SHOWN     = 10;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
  } conversion_t;

  // {next state, digit} by [state][octant]
  localparam logic [6:0] ENC_STEP [0:11][0:7] = '{
    '{7'd8,  7'd17, 7'd27, 7'd18, 7'd47, 7'd38, 7'd28, 7'd37},
    '{7'd16, 7'd71, 7'd1,  7'd62, 7'd51, 7'd52, 7'd2,  7'd61},
    '{7'd0,  7'd75, 7'd95, 7'd76, 7'd9,  7'd10, 7'd86, 7'd85},
    '{7'd4,  7'd77, 7'd55, 7'd78, 7'd3,  7'd66, 7'd80, 7'd65},
    '{7'd50, 7'd49, 7'd45, 7'd46, 7'd67, 7'd88, 7'd68, 7'd7},
    '{7'd6,  7'd57, 7'd39, 7'd72, 7'd5,  7'd58, 7'd84, 7'd83},
    '{7'd12, 7'd11, 7'd29, 7'd90, 7'd79, 7'd32, 7'd30, 7'd89},
    '{7'd74, 7'd91, 7'd73, 7'd40, 7'd69, 7'd92, 7'd70, 7'd15},
    '{7'd14, 7'd13, 7'd81, 7'd82, 7'd63, 7'd36, 7'd24, 7'd35},
    '{7'd20, 7'd31, 7'd19, 7'd56, 7'd53, 7'd54, 7'd42, 7'd41},
    '{7'd26, 7'd93, 7'd43, 7'd44, 7'd25, 7'd94, 7'd64, 7'd23},
    '{7'd22, 7'd87, 7'd21, 7'd60, 7'd33, 7'd48, 7'd34, 7'd59}
  };

  // {next state, octant} by [state][digit]
  localparam logic [6:0] DEC_STEP [0:11][0:7] = '{
    '{7'd8,  7'd17, 7'd19, 7'd26, 7'd30, 7'd39, 7'd37, 7'd44},
    '{7'd16, 7'd2,  7'd6,  7'd52, 7'd53, 7'd63, 7'd59, 7'd65},
    '{7'd0,  7'd12, 7'd13, 7'd73, 7'd75, 7'd87, 7'd86, 7'd90},
    '{7'd86, 7'd71, 7'd69, 7'd4,  7'd0,  7'd73, 7'd75, 7'd50},
    '{7'd93, 7'd49, 7'd48, 7'd68, 7'd70, 7'd42, 7'd43, 7'd7},
    '{7'd75, 7'd57, 7'd61, 7'd87, 7'd86, 7'd4,  7'd0,  7'd34},
    '{7'd37, 7'd95, 7'd91, 7'd9,  7'd8,  7'd26, 7'd30, 7'd76},
    '{7'd43, 7'd74, 7'd72, 7'd89, 7'd93, 7'd68, 7'd70, 7'd15},
    '{7'd30, 7'd82, 7'd83, 7'd39, 7'd37, 7'd9,  7'd8,  7'd60},
    '{7'd59, 7'd47, 7'd46, 7'd18, 7'd16, 7'd52, 7'd53, 7'd25},
    '{7'd70, 7'd28, 7'd24, 7'd42, 7'd43, 7'd89, 7'd93, 7'd23},
    '{7'd53, 7'd36, 7'd38, 7'd63, 7'd59, 7'd18, 7'd16, 7'd81}
  };

  conversion_t awaited_conversions[$];
  int          n_bad  = 0;
  int          n_good = 0;

  // One automaton step per level, top level first. Fields the command
  // doesn't fill stay zero.
  function automatic conversion_t predict_conversion(
    input logic             op,
    input logic [CRD_W-1:0] xc,
    input logic [CRD_W-1:0] yc,
    input logic [CRD_W-1:0] zc,
    input logic [IDX_W-1:0] ic,
    input logic [LVL_W-1:0] depth
  );
    conversion_t r;
    int          lvl;
    logic [3:0]  st;
    logic [6:0]  entry;
    logic [2:0]  sel;
    r   = '0;
    st  = '0;
    lvl = (depth > MAX_LEVEL) ? MAX_LEVEL : int'(depth);
    for (int k = lvl; k > 0; k--) begin
      if (op == CMD_ENCODE) begin
        sel   = {zc[k-1], yc[k-1], xc[k-1]};
        entry = ENC_STEP[st][sel];
        r.idx = {r.idx[IDX_W-4:0], entry[2:0]};
      end else begin
        sel   = ic[3*(k-1) +: 3];
        entry = DEC_STEP[st][sel];
        r.x   = {r.x[CRD_W-2:0], entry[0]};
        r.y   = {r.y[CRD_W-2:0], entry[1]};
        r.z   = {r.z[CRD_W-2:0], entry[2]};
      end
      st = entry[6:3];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    conversion_t want;
    conversion_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        awaited_conversions.push_back(predict_conversion(cmd, x_coord, y_coord, z_coord,
                                                         hilbert_index, depth_level));
      if (out_valid && !out_stall) begin
        got = {index_out, x_out, y_out, z_out};
        if (awaited_conversions.size() == 0) begin
          n_bad++;
          if (n_bad <= SHOWN)
            $display("%0t: result transaction with nothing pending: idx %h x %h y %h z %h",
                     $realtime, got.idx, got.x, got.y, got.z);
        end else begin
          want = awaited_conversions.pop_front();
          if (got.idx != want.idx || got.x != want.x || got.y != want.y ||
              got.z != want.z) begin
            n_bad++;
            if (n_bad <= SHOWN) begin
              $display("%0t: mismatch #%0d", $realtime, n_bad);
              $display("  index_out exp %h got %h", want.idx, got.idx);
              $display("  x_out exp %h got %h  y_out exp %h got %h  z_out exp %h got %h",
                       want.x, got.x, want.y, got.y, want.z, got.z);
            end
          end else begin
            n_good++;
          end
        end
      end
    end
    // published with NBAs so the stimulus side reads stable values
    mismatches  <= n_bad;
    matched     <= n_good;
    outstanding <= awaited_conversions.size();
  end

endmodule

FILE: dv/hilbert_3d_codec_tb.sv
`timescale 1ns / 1ps
module hilbert_3d_codec_tb;
  import hc3d_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 2 * COORD_BITS_DEF + 8;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic             cmd           = CMD_ENCODE;
  logic [CRD_W-1:0] x_coord       = '0;
  logic [CRD_W-1:0] y_coord       = '0;
  logic [CRD_W-1:0] z_coord       = '0;
  logic [IDX_W-1:0] hilbert_index = '0;
  logic [LVL_W-1:0] depth_level   = '0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [IDX_W-1:0] index_out;
  logic [CRD_W-1:0] x_out;
  logic [CRD_W-1:0] y_out;
  logic [CRD_W-1:0] z_out;

  int mismatches;
  int outstanding;
  int matched;
  int cycles     = 0;
  int n_enc      = 0;
  int n_dec      = 0;
  int n_clamped  = 0;
  int n_zero_lvl = 0;
  bit send_gaps  = 1'b1;
  bit recv_stalls = 1'b1;

  always #4 clk = ~clk;

  hilbert_3d_codec dut (.*);

  hilbert_3d_codec_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("hilbert_3d_codec_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= recv_stalls && ($urandom_range(99) < 22);
  end

  // Returns at the edge that takes the transaction, plus any idle gap after it.
  task automatic send_conversion(
    input logic             op,
    input logic [CRD_W-1:0] xc,
    input logic [CRD_W-1:0] yc,
    input logic [CRD_W-1:0] zc,
    input logic [IDX_W-1:0] ic,
    input logic [LVL_W-1:0] lvl
  );
    in_valid      <= 1'b1;
    cmd           <= op;
    x_coord       <= xc;
    y_coord       <= yc;
    z_coord       <= zc;
    hilbert_index <= ic;
    depth_level   <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == CMD_ENCODE) n_enc++;
    else n_dec++;
    if (lvl > COORD_BITS_DEF) n_clamped++;
    if (lvl == 0) n_zero_lvl++;
    if (send_gaps)
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
  endtask

  task automatic random_conversion();
    int               pick;
    logic [LVL_W-1:0] lvl;
    pick = $urandom_range(99);
    if (pick < 5) lvl = '0;
    else if (pick < 15) lvl = LVL_W'($urandom_range(31, COORD_BITS_DEF + 1));
    else if (pick < 40) lvl = LVL_W'(COORD_BITS_DEF);
    else lvl = LVL_W'($urandom_range(COORD_BITS_DEF - 1, 1));
    send_conversion($urandom_range(1) ? CMD_DECODE : CMD_ENCODE,
                    CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom),
                    IDX_W'({$urandom, $urandom}), lvl);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // level zero, full width, clamped levels; some unused inputs left nonzero
    send_conversion(CMD_ENCODE, '1, '1, '1, '1, '0);
    send_conversion(CMD_DECODE, '1, '1, '1, '1, '0);
    send_conversion(CMD_ENCODE, '1, '1, '1, '0, LVL_W'(COORD_BITS_DEF));
    send_conversion(CMD_ENCODE, '0, '0, '0, '1, LVL_W'(COORD_BITS_DEF));
    send_conversion(CMD_DECODE, '0, '0, '0, '1, LVL_W'(COORD_BITS_DEF));
    send_conversion(CMD_DECODE, '1, '1, '1, '0, LVL_W'(COORD_BITS_DEF));
    send_conversion(CMD_ENCODE, 21'h15555, 21'h0aaaa, 21'h1f0f0, '0, '1);
    send_conversion(CMD_DECODE, '0, '0, '0, 63'h5a5a_5a5a_a5a5_a5a5,
                    LVL_W'(COORD_BITS_DEF + 1));
    // single level, every octant and digit, junk above the level
    for (int o = 0; o < 8; o++)
      send_conversion(CMD_ENCODE, {20'($urandom), o[0]}, {20'($urandom), o[1]},
                      {20'($urandom), o[2]}, '0, LVL_W'(1));
    for (int d = 0; d < 8; d++)
      send_conversion(CMD_DECODE, '0, '0, '0, {60'({$urandom, $urandom}), 3'(d)},
                      LVL_W'(1));

    repeat (200) random_conversion();

    // hold off until the pipeline is empty
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    // back-to-back stretch, no gaps and no stalls
    send_gaps   = 1'b0;
    recv_stalls <= 1'b0;
    repeat (150) random_conversion();

    send_gaps   = 1'b1;
    recv_stalls <= 1'b1;
    repeat (200) random_conversion();

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d encode, %0d decode transactions, %0d at level zero, %0d clamped",
             n_enc, n_dec, n_zero_lvl, n_clamped);
    $display("Results: %0d matched, %0d mismatched, under random gaps and output stalls",
             matched, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("hilbert_3d_codec_tb: PASS");
    else
      $display("hilbert_3d_codec_tb: FAIL");
    $finish;
  end

endmodule
